@@ hdl/pld_pkg.sv @@
// Shared constants and types for the point light distance attenuation block.
`default_nettype none
package pld_pkg;

  // Fixed point layout
  localparam int COORD_FRAC = 12;  // Q.12 coordinates and distance
  localparam int COEF_W     = 24;  // Q8.16 coefficients
  localparam int COEF_FRAC  = 16;
  localparam int LIMIT_W    = 16;
  localparam int FALLOFF_W  = 32;  // falloff clamps to Q16.16
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X     = 3'd0,
    CFG_LIGHT_Y     = 3'd1,
    CFG_LIGHT_Z     = 3'd2,
    CFG_CONST_COEF  = 3'd3,
    CFG_LIN_COEF    = 3'd4,
    CFG_QUAD_COEF   = 3'd5,
    CFG_NEAR_LIMIT  = 3'd6
  } cfg_idx_t;

  // Flags carried alongside the reciprocal divider
  typedef struct packed {
    logic cap;         // answer is exactly one
    logic degenerate;  // falloff below the near zero limit
  } pld_tag_t;

endpackage
`default_nettype wire

@@ hdl/pld_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module pld_sqrt #(
  parameter int SW = 50,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [SW-1:0] in_rad,
  output logic          out_valid,
  output logic [DW-1:0] out_root
);

  localparam int TW = SW + 2;

  logic          v_r    [0:DW];
  logic [SW-1:0] rem_r  [0:DW];
  logic [DW-1:0] root_r [0:DW];

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_rad;
      root_r[0] <= '0;
    end
  end

  // One stage per root bit, most significant first
  for (genvar s = 0; s < DW; s++) begin : g_stage
    localparam int B = DW - 1 - s;
    logic [TW-1:0] trial;
    logic [TW-1:0] rem_ext;
    logic [TW-1:0] diff;
    logic          take;

    assign trial   = (TW'(root_r[s]) << (B + 1)) | (TW'(1) << (2 * B));
    assign rem_ext = TW'(rem_r[s]);
    assign take    = rem_ext >= trial;
    assign diff    = rem_ext - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= take ? diff[SW-1:0] : rem_r[s];
        root_r[s+1] <= root_r[s] | (DW'(take) << B);
      end
    end
  end

  assign out_valid = v_r[DW];
  assign out_root  = root_r[DW];

endmodule
`default_nettype wire

@@ hdl/pld_div.sv @@
// Pipelined restoring divider forming 2^(QW-1+16) / den, one quotient bit per stage.
`default_nettype none
module pld_div #(
  parameter int QW = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pld_pkg::FALLOFF_W-1:0] in_den,
  input  pld_pkg::pld_tag_t             in_tag,
  output logic                          out_valid,
  output logic [QW-1:0]                 out_quo,
  output pld_pkg::pld_tag_t             out_tag
);

  import pld_pkg::*;

  // Partial remainder once the leading dividend bits are consumed (den >= 2^16)
  localparam logic [FALLOFF_W-1:0] REM_INIT = FALLOFF_W'(1) << (COEF_FRAC - 1);

  logic                 v_r   [0:QW];
  logic [FALLOFF_W-1:0] den_r [0:QW];
  logic [FALLOFF_W-1:0] rem_r [0:QW];
  logic [QW-1:0]        quo_r [0:QW];
  pld_tag_t             tag_r [0:QW];

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= in_den;
      rem_r[0] <= REM_INIT;
      quo_r[0] <= '0;
      tag_r[0] <= in_tag;
    end
  end

  // Shift, compare and subtract per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [FALLOFF_W:0] sh;
    logic [FALLOFF_W:0] diff;
    logic               take;

    assign sh   = {rem_r[k], 1'b0};
    assign take = sh >= {1'b0, den_r[k]};
    assign diff = sh - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= take ? diff[FALLOFF_W-1:0] : sh[FALLOFF_W-1:0];
        quo_r[k+1] <= quo_r[k] | (QW'(take) << B);
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_tag   = tag_r[QW];

endmodule
`default_nettype wire

@@ hdl/point_light_distance_attenuation.sv @@
// Top level: point light attenuation pipeline with configuration registers.
//
// Usage:
//   Input words (in_point_x/y/z, signed Q12.12) enter on in_valid/in_ready.
//   Each gives one output word: out_attenuation (Q1.RESULT_FRAC_BITS, one is
//   2^RESULT_FRAC_BITS) and out_falloff_degenerate, on out_valid/out_ready.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while idle;
//   index 7 is ignored.
//   Throughput: one word per cycle while the output is not stalled.
//   Stages: two difference/square stages, the square root pipeline (one
//   bit per stage, DW being the root width, 25 at COORD_WIDTH 24), five
//   falloff stages, the reciprocal divider (one quotient bit per stage)
//   and the output register.
//   The whole pipeline advances as one; it halts while an output word is
//   held and out_ready is low, and in_ready follows. Nothing is lost.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults: light at the origin, constant term one, other terms
//   zero, near zero limit one lsb.
`default_nettype none
module point_light_distance_attenuation #(
  parameter int COORD_WIDTH      = 24,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_point_x,
  input  logic signed [COORD_WIDTH-1:0]       in_point_y,
  input  logic signed [COORD_WIDTH-1:0]       in_point_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [RESULT_FRAC_BITS:0]           out_attenuation,
  output logic                                out_falloff_degenerate,
  input  logic                                cfg_we,
  input  logic [pld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > pld_pkg::COEF_W) ? COORD_WIDTH : pld_pkg::COEF_W)-1:0]
                                              cfg_wdata
);

  import pld_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int RF   = RESULT_FRAC_BITS;
  localparam int SQW  = 2 * CW;
  localparam int SUMW = 2 * CW + 2;
  localparam int SW   = (SUMW > 64) ? 64 : SUMW;
  localparam int DW   = (SW + 1) / 2;
  localparam int QDW  = COEF_W + DW;
  localparam int TTW  = DW + 13;
  localparam int TLW  = (TTW + 1) / 2;
  localparam int THW  = TTW - TLW;
  localparam int PW   = TTW + DW;
  localparam int FRW  = PW - COORD_FRAC + 1;
  localparam int QW   = RF + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << RF;

  // Configuration registers
  logic [CW-1:0]      light_x_r, light_y_r, light_z_r;
  logic [COEF_W-1:0]  constant_coef_r, linear_coef_r, quadratic_coef_r;
  logic [LIMIT_W-1:0] near_zero_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r         <= '0;
      light_y_r         <= '0;
      light_z_r         <= '0;
      constant_coef_r   <= COEF_W'(1) << COEF_FRAC;
      linear_coef_r     <= '0;
      quadratic_coef_r  <= '0;
      near_zero_limit_r <= LIMIT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIGHT_X:    light_x_r         <= cfg_wdata[CW-1:0];
        CFG_LIGHT_Y:    light_y_r         <= cfg_wdata[CW-1:0];
        CFG_LIGHT_Z:    light_z_r         <= cfg_wdata[CW-1:0];
        CFG_CONST_COEF: constant_coef_r   <= cfg_wdata[COEF_W-1:0];
        CFG_LIN_COEF:   linear_coef_r     <= cfg_wdata[COEF_W-1:0];
        CFG_QUAD_COEF:  quadratic_coef_r  <= cfg_wdata[COEF_W-1:0];
        CFG_NEAR_LIMIT: near_zero_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a held output word is stalled
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] p, input logic [CW-1:0] l);
    logic [CW:0] d;
    logic [CW:0] n;
    d = {p[CW-1], p} - {l[CW-1], l};
    n = -d;
    return d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  // Stage 1: absolute differences
  logic          v1_r;
  logic [CW-1:0] adx_r, ady_r, adz_r;

  // Stage 2: squares
  logic           v2_r;
  logic [SQW-1:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r <= abs_diff(in_point_x, light_x_r);
      ady_r <= abs_diff(in_point_y, light_y_r);
      adz_r <= abs_diff(in_point_z, light_z_r);
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
      sqz_r <= adz_r * adz_r;
    end
  end

  // Sum of squares, saturated to SW bits (at most 64), into the root pipeline
  logic [SUMW-1:0] sum;
  logic [SW-1:0]   sum_sat;
  assign sum     = SUMW'(sqx_r) + SUMW'(sqy_r) + SUMW'(sqz_r);
  assign sum_sat = (|(sum >> SW)) ? {SW{1'b1}} : sum[SW-1:0];

  logic          rt_valid;
  logic [DW-1:0] rt_root;

  pld_sqrt #(.SW(SW), .DW(DW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .in_rad    (sum_sat),
    .out_valid (rt_valid),
    .out_root  (rt_root)
  );

  // Falloff stages: q*d, t, partial products of t*d, product, f
  logic                 v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [QDW-1:0]       qd4_r;
  logic [DW-1:0]        d4_r, d5_r;
  logic [TTW-1:0]       t5_r;
  logic [TLW+DW-1:0]    pl6_r;
  logic [THW+DW-1:0]    ph6_r;
  logic [PW-1:0]        prod7_r;
  logic [FALLOFF_W-1:0] f8_r;
  logic [FRW-1:0]       f_raw;

  assign f_raw = FRW'(prod7_r >> COORD_FRAC) + FRW'(constant_coef_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (adv) begin
      v4_r <= rt_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qd4_r   <= quadratic_coef_r * rt_root;
      d4_r    <= rt_root;
      t5_r    <= TTW'(qd4_r >> COORD_FRAC) + TTW'(linear_coef_r);
      d5_r    <= d4_r;
      pl6_r   <= t5_r[TLW-1:0] * d5_r;
      ph6_r   <= t5_r[TTW-1:TLW] * d5_r;
      prod7_r <= (PW'(ph6_r) << TLW) + PW'(pl6_r);
      f8_r    <= (|f_raw[FRW-1:FALLOFF_W]) ? {FALLOFF_W{1'b1}} : f_raw[FALLOFF_W-1:0];
    end
  end

  // Flags for the special answers, then the reciprocal
  pld_tag_t tag8;
  assign tag8.degenerate = f8_r < FALLOFF_W'(near_zero_limit_r);
  assign tag8.cap        = tag8.degenerate || (f8_r[FALLOFF_W-1:COEF_FRAC] == '0);

  logic          dv_valid;
  logic [QW-1:0] dv_quo;
  pld_tag_t      dv_tag;

  pld_div #(.QW(QW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v8_r),
    .in_den    (f8_r),
    .in_tag    (tag8),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // Output register
  logic [QW-1:0] out_attenuation_r;
  logic          out_falloff_degenerate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_attenuation_r        <= dv_tag.cap ? ONE : dv_quo;
      out_falloff_degenerate_r <= dv_tag.degenerate;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_attenuation        = out_attenuation_r;
  assign out_falloff_degenerate = out_falloff_degenerate_r;

  // Checks
  a_att_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_attenuation_r <= ONE)
    else $error("attenuation above one");

  a_degen_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_falloff_degenerate_r |-> out_attenuation_r == ONE)
    else $error("degenerate falloff without unit attenuation");

  a_const_only: assert property (@(posedge clk) disable iff (!rst_n)
    v8_r && quadratic_coef_r == '0 && linear_coef_r == '0
      |-> f8_r == FALLOFF_W'(constant_coef_r))
    else $error("falloff differs from constant term with zero distance terms");

endmodule
`default_nettype wire

@@ test/point_light_distance_attenuation_tb.sv @@
// Testbench for the point light distance attenuation pipeline, with scoreboard.
`timescale 1ns / 1ps
module point_light_distance_attenuation_tb;
  import pld_pkg::*;

  localparam int CW         = 24;
  localparam int RF         = 16;
  localparam int DRAIN_CYC  = 80;      // beyond the pipeline depth
  localparam int CYC_LIMIT  = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic [RF:0] att;
    logic        degen;
  } atten_word_t;

  // Scoreboard: own copy of the registers and the attenuation predictor
  class atten_scoreboard;
    logic signed [CW-1:0] lx, ly, lz;
    logic [COEF_W-1:0]    c_coef, l_coef, q_coef;
    logic [LIMIT_W-1:0]   near_lim;
    atten_word_t          expected_q[$];
    int                   errors;

    function new();
      lx = '0; ly = '0; lz = '0;
      c_coef = 24'd65536; l_coef = '0; q_coef = '0;
      near_lim = 16'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] v);
      case (idx)
        CFG_LIGHT_X:    lx = v;
        CFG_LIGHT_Y:    ly = v;
        CFG_LIGHT_Z:    lz = v;
        CFG_CONST_COEF: c_coef = v;
        CFG_LIN_COEF:   l_coef = v;
        CFG_QUAD_COEF:  q_coef = v;
        CFG_NEAR_LIMIT: near_lim = v[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Sum of squares stays below 2^50 and t*d below 2^63, so no saturation in 64 bits
    function void note_point(logic signed [CW-1:0] px, py, pz);
      longint dx, dy, dz;
      longint unsigned sum, root_d, t, f, a;
      atten_word_t w;
      dx = longint'(px) - longint'(lx);
      dy = longint'(py) - longint'(ly);
      dz = longint'(pz) - longint'(lz);
      sum = dx * dx + dy * dy + dz * dz;
      root_d = int_sqrt(sum);
      t = ((longint'(q_coef) * root_d) >> COORD_FRAC) + l_coef;
      f = ((t * root_d) >> COORD_FRAC) + c_coef;
      if (f > 64'hFFFF_FFFF) f = 64'hFFFF_FFFF;
      w.degen = (f < near_lim);
      if (w.degen || f == 0) begin
        a = 64'd1 << RF;
      end else begin
        a = (64'd1 << (RF + COEF_FRAC)) / f;
        if (a > (64'd1 << RF)) a = 64'd1 << RF;
      end
      w.att = a[RF:0];
      expected_q.insert(expected_q.size(), w);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_word(logic [RF:0] att, logic degen);
      atten_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", att, 0);
      end else begin
        w = expected_q.pop_front();
        if (att !== w.att) report_mismatch("attenuation", att, w.att);
        if (degen !== w.degen) report_mismatch("degenerate flag", degen, w.degen);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RF:0] out_attenuation;
  logic out_falloff_degenerate;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  atten_scoreboard sb = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  pressure_req   = 1'b0;
  logic hold_off      = 1'b0;
  int  cycles         = 0;

  point_light_distance_attenuation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_attenuation(out_attenuation), .out_falloff_degenerate(out_falloff_degenerate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("point_light_distance_attenuation_tb: FAIL");
      $finish;
    end
  end

  // Receiver with random stalls
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off on request, so the pipeline fills and stalls its input
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_attenuation, out_falloff_degenerate);
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task send_point(logic signed [CW-1:0] px, py, pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (!in_ready);
    sb.note_point(px, py, pz);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function logic [23:0] rand_coef();
    return 24'($urandom >> $urandom_range(8, 31));
  endfunction

  // Either anywhere, or a small offset from the light
  function logic signed [CW-1:0] rand_coord(logic signed [CW-1:0] centre);
    if ($urandom_range(2) == 0) return CW'($urandom);
    return centre + (CW'(int'($urandom_range(16383)) - 8192) <<< $urandom_range(4));
  endfunction

  task random_phase(int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(sb.lx), rand_coord(sb.ly), rand_coord(sb.lz));
  endtask

  task random_config();
    write_reg(CFG_LIGHT_X, 24'($urandom));
    write_reg(CFG_LIGHT_Y, 24'($urandom));
    write_reg(CFG_LIGHT_Z, 24'($urandom));
    write_reg(CFG_CONST_COEF, rand_coef());
    write_reg(CFG_LIN_COEF, rand_coef());
    write_reg(CFG_QUAD_COEF, rand_coef());
    write_reg(CFG_NEAR_LIMIT, $urandom_range(2) == 0 ? 24'($urandom) : 24'($urandom_range(3)));
    end_writes();
  endtask

  localparam logic signed [CW-1:0] CMAX = 24'h7FFFFF;
  localparam logic signed [CW-1:0] CMIN = 24'h800000;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults, coordinate extremes
    send_point('0, '0, '0);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMIN, 24'sd4096);
    send_point(-24'sd1, 24'sd1, '0);
    drain();

    // Zero falloff with zero limit: capped at one, flag low; ignored index too
    write_reg(CFG_CONST_COEF, '0);
    write_reg(CFG_LIN_COEF, '0);
    write_reg(CFG_QUAD_COEF, '0);
    write_reg(CFG_NEAR_LIMIT, '0);
    write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
    end_writes();
    send_point('0, '0, '0);
    send_point(CMAX, CMIN, CMAX);
    drain();

    // Degenerate falloff under the maximum limit
    write_reg(CFG_NEAR_LIMIT, 24'hFFFFFF);
    write_reg(CFG_LIN_COEF, 24'd1);
    end_writes();
    send_point('0, '0, '0);
    send_point(24'sd4096, '0, '0);
    send_point(CMAX, CMAX, CMAX);
    drain();

    // Saturated falloff: all terms at maximum, light at the far corner
    write_reg(CFG_LIGHT_X, CMIN);
    write_reg(CFG_LIGHT_Y, CMIN);
    write_reg(CFG_LIGHT_Z, CMAX);
    write_reg(CFG_CONST_COEF, 24'hFFFFFF);
    write_reg(CFG_LIN_COEF, 24'hFFFFFF);
    write_reg(CFG_QUAD_COEF, 24'hFFFFFF);
    write_reg(CFG_NEAR_LIMIT, '0);
    end_writes();
    send_point(CMAX, CMAX, CMIN);
    send_point(CMIN, CMIN, CMAX);
    send_point('0, '0, '0);
    send_point(CMAX, CMIN, CMIN);
    drain();

    // Random phases under different idling patterns
    random_config();
    random_phase(210);
    drain();

    send_idle_pct = 59;
    random_config();
    random_phase(210);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 59;
    random_config();
    pressure_req = 1'b1;
    random_phase(210);
    drain();

    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_config();
    random_phase(210);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("point_light_distance_attenuation_tb: PASS");
    end else begin
      $display("point_light_distance_attenuation_tb: FAIL");
    end
    $finish;
  end
endmodule
